// ===== design/pci_pkg.sv =====
// Shared types and constants for the palette color indexer.
// No dependencies; used by pci_ctrl, pci_datapath and palette_color_indexer.
package pci_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int COLOR_W     = 24;
    localparam int IDX_W       = $clog2(PAL_ENTRIES);
    localparam int CNT_W       = $clog2(PAL_ENTRIES + 1);
    localparam int ENTRY_W     = 8;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;

    // action codes carried in s_tuser
    localparam logic ACT_MAP  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    typedef struct packed {
        logic load;     // capture a new item, set the scan pointer
        logic advance;  // read the next entry, advance the pointer
        logic finish;   // form the result, commit an insert
    } cmd_t;

    typedef struct packed {
        logic done;     // current compare settles the item
    } status_t;

endpackage

// ===== design/palette_color_indexer.sv =====
// Top level of the palette color indexer: controller plus datapath.
// Depends on pci_pkg, pci_ctrl and pci_datapath.
// Sequence: an accepted item is loaded, its first entry is read in ST_WAIT, and
//   ST_SCAN compares one entry per cycle (bounded by the single read port of the
//   color memory) until a read, a map hit or a miss settles it; the result is registered.
// Overlap: the next item is accepted while the previous result still waits in
//   the output register; a settled item waits in ST_SCAN until that register is free.
// Reset: rst_n clears the fill count, so the palette starts empty; memory is not cleared.
module palette_color_indexer (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pci_pkg::S_DATA_W-1:0]  s_tdata,  // [23:0] pixel_color, [31:24] entry_index
    input  logic [pci_pkg::S_USER_W-1:0]  s_tuser,  // [0] action
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pci_pkg::M_DATA_W-1:0]  m_tdata,  // [7:0] palette_index, [31:8] entry_color,
                                                    // [40:32] colors_used, [47:41] zero
    output logic [pci_pkg::M_USER_W-1:0]  m_tuser   // [0] was_inserted, [1] overflow
);
    import pci_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence item handshakes and scan steps
    pci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the palette, walk it one entry a cycle, form each result
    pci_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== design/pci_ctrl.sv =====
// Controller state machine for the palette color indexer.
// Depends on pci_pkg; drives command signals into pci_datapath.
module pci_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  pci_pkg::status_t status,
    output pci_pkg::cmd_t    cmd
);
    import pci_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!status.done)
                begin
                    cmd.advance = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_WAIT))
        else $error("accepted item did not start a fetch");

    a_wait_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |=> (state_reg == ST_SCAN))
        else $error("fetch cycle not followed by scan");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken result");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result valid without a finished item");

endmodule

// ===== design/pci_datapath.sv =====
// Datapath for the palette color indexer: color memory, scan pointer,
// fill count and result register. Depends on pci_pkg; driven by pci_ctrl.
module pci_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pci_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [pci_pkg::S_USER_W-1:0]      s_tuser,
    input  pci_pkg::cmd_t                     cmd,
    output pci_pkg::status_t                  status,
    output logic [pci_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [pci_pkg::M_USER_W-1:0]      m_tuser
);
    import pci_pkg::*;

    logic [COLOR_W-1:0] color_mem [PAL_ENTRIES];

    logic               action_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   ptr_next;
    logic [COLOR_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]   cmp_idx_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    logic [IDX_W-1:0]   res_index_reg;
    logic [COLOR_W-1:0] res_color_reg;
    logic               res_ins_reg;
    logic               res_ovf_reg;
    logic [CNT_W-1:0]   res_used_reg;

    logic               in_range;
    logic               hit;
    logic               is_read;
    logic               has_room;
    logic               do_insert;
    logic [IDX_W-1:0]   index_next;
    logic [COLOR_W-1:0] ecolor_next;

    assign is_read   = (action_reg == ACT_READ);
    assign in_range  = (cmp_idx_reg < fill_reg);
    assign hit       = !is_read && in_range && (rd_data_reg == color_reg);
    assign has_room  = (fill_reg < CNT_W'(PAL_ENTRIES));
    assign status.done = is_read || hit || !in_range;
    assign do_insert = cmd.finish && !is_read && !hit && has_room;

    always_comb
    begin
        index_next  = '0;
        ecolor_next = '0;
        if (is_read)
        begin
            ecolor_next = in_range ? rd_data_reg : '0;
        end
        else if (hit)
        begin
            index_next = cmp_idx_reg[IDX_W-1:0];
        end
        else if (has_room)
        begin
            index_next = fill_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (s_tuser[0] == ACT_READ) ? CNT_W'(s_tdata[COLOR_W +: ENTRY_W]) : '0;
        end
        else if (cmd.advance)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    assign fill_next = do_insert ? fill_reg + CNT_W'(1) : fill_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            rd_data_reg <= color_mem[ptr_reg[IDX_W-1:0]];
            cmp_idx_reg <= ptr_reg;
        end
        if (do_insert)
        begin
            color_mem[fill_reg[IDX_W-1:0]] <= color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= s_tuser[0];
            color_reg  <= s_tdata[COLOR_W-1:0];
        end
        if (cmd.finish)
        begin
            res_index_reg <= index_next;
            res_color_reg <= ecolor_next;
            res_ins_reg   <= do_insert;
            res_ovf_reg   <= !is_read && !hit && !has_room;
            res_used_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    assign m_tdata = {(M_DATA_W - IDX_W - COLOR_W - CNT_W)'(0),
                      res_used_reg, res_color_reg, res_index_reg};
    assign m_tuser = {res_ovf_reg, res_ins_reg};

endmodule

// ===== verif/tb_palette_color_indexer.sv =====
// Self-checking testbench for palette_color_indexer: map and read items on the
// input stream, answers checked one by one against a palette tracker class.
// Depends on pci_pkg and the palette_color_indexer RTL.
`timescale 1ns / 100ps

module tb_palette_color_indexer;

    import pci_pkg::*;

    // Cycles without any transaction before the run is declared hung. The
    // slowest answer is a full-table scan plus a stall burst on each side,
    // so this leaves a wide margin.
    localparam int HANG_LIMIT     = 2000;
    localparam int RANDOM_ITEMS   = 1080;
    localparam int QUIET_TAIL     = 150;   // last items run with no idling
    localparam int DRAIN_EVERY    = 250;   // sender waits for all answers this often
    localparam int SETTLE_CYCLES  = 300;   // longer than the slowest scan
    localparam int MAX_REPORTS    = 30;

    // One answer of the block, split into its fields.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] ecolor;
        logic               ins;
        logic               ovf;
        logic [CNT_W-1:0]   used;
    } answer_t;

    // Tracks the palette the block should be building and the answers it owes.
    class palette_tracker;
        logic [COLOR_W-1:0] stored [PAL_ENTRIES];
        int unsigned        filled;
        answer_t            owed_answers[$];
        int unsigned        errors, checked, inserts, hits, overflows, reads;

        function new();
            filled = 0;
            errors = 0;
            checked = 0;
            inserts = 0;
            hits = 0;
            overflows = 0;
            reads = 0;
        endfunction

        // Advance the palette by one item and return the answer it causes.
        function answer_t predict_answer(logic act, logic [COLOR_W-1:0] color,
                                         logic [ENTRY_W-1:0] entry);
            answer_t a;
            bit      found;
            int      k;
            a = '0;
            found = 0;
            if (act == ACT_READ)
            begin
                reads++;
                if (entry < filled)
                    a.ecolor = stored[entry];
            end
            else
            begin
                for (k = 0; k < filled && !found; k++)
                begin
                    if (stored[k] == color)
                    begin
                        found = 1;
                        a.idx = IDX_W'(k);
                    end
                end
                if (found)
                    hits++;
                else if (filled < PAL_ENTRIES)
                begin
                    stored[filled] = color;
                    a.idx = IDX_W'(filled);
                    a.ins = 1'b1;
                    filled++;
                    inserts++;
                end
                else
                begin
                    a.ovf = 1'b1;
                    overflows++;
                end
            end
            a.used = CNT_W'(filled);
            return a;
        endfunction

        function void note_pixel(logic act, logic [COLOR_W-1:0] color,
                                 logic [ENTRY_W-1:0] entry);
            owed_answers.push_back(predict_answer(act, color, entry));
        endfunction

        function void report_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s differs, expected %h actual %h",
                             $time, field, want, got);
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (owed_answers.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: answer with nothing owed, expected none actual %h",
                             $time, got);
                return;
            end
            want = owed_answers.pop_front();
            checked++;
            report_field("palette_index", 32'(want.idx),    32'(got.idx));
            report_field("entry_color",   32'(want.ecolor), 32'(got.ecolor));
            report_field("was_inserted",  32'(want.ins),    32'(got.ins));
            report_field("overflow",      32'(want.ovf),    32'(got.ovf));
            report_field("colors_used",   32'(want.used),   32'(got.used));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    palette_tracker tracker = new();

    bit idle_on;       // random idling allowed on both sides
    int quiet_cycles;  // cycles since the last transaction

    palette_color_indexer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [23:0] pixel_color, [31:24] entry_index
        .s_tuser  (s_tuser),   // [0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] palette_index, [31:8] entry_color, [40:32] colors_used
        .m_tuser  (m_tuser)    // [0] was_inserted, [1] overflow
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drive one item from the falling edge and hold it until the block takes it.
    // Valid stays high on return, so back-to-back items keep valid asserted between them.
    task automatic send_item(logic act, logic [COLOR_W-1:0] color,
                             logic [ENTRY_W-1:0] entry);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {entry, color};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_pixel(act, color, entry);
    endtask

    // Drop valid for a burst of idle cycles.
    task automatic hold_input(int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Drop valid and wait until every owed answer has come back.
    task automatic drain_answers();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.owed_answers.size() != 0)
            @(posedge clk);
    endtask

    // Pick a random item. Maps mostly reuse stored colors or bring fresh ones,
    // with fresh colors favored until the palette fills so that the full-table
    // overflow path gets a long stretch of the run.
    task automatic send_random_item();
        logic               act;
        logic [COLOR_W-1:0] color;
        logic [ENTRY_W-1:0] entry;
        int                 fresh_pct;
        act   = ($urandom_range(0, 3) == 0) ? ACT_READ : ACT_MAP;
        color = COLOR_W'($urandom);
        entry = ENTRY_W'($urandom);
        fresh_pct = (tracker.filled < PAL_ENTRIES) ? 60 : 35;
        if (act == ACT_MAP && tracker.filled > 0 && $urandom_range(1, 100) > fresh_pct)
            color = tracker.stored[$urandom_range(0, tracker.filled - 1)];
        if (act == ACT_READ)
        begin
            case ($urandom_range(0, 3))
                0: entry = ENTRY_W'(tracker.filled);        // first unfilled entry
                1: entry = ENTRY_W'(PAL_ENTRIES - 1);
                2: if (tracker.filled > 0)
                       entry = ENTRY_W'($urandom_range(0, tracker.filled - 1));
                default: ;
            endcase
        end
        send_item(act, color, entry);
    endtask

    // Result side: stall in random bursts while idling is on, else stay ready.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Check every accepted answer against the oldest owed one.
    always @(posedge clk)
    begin
        answer_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.idx    = m_tdata[IDX_W-1:0];
            got.ecolor = m_tdata[IDX_W +: COLOR_W];
            got.used   = m_tdata[IDX_W + COLOR_W +: CNT_W];
            got.ins    = m_tuser[0];
            got.ovf    = m_tuser[1];
            tracker.check_answer(got);
        end
    end

    // Hang detection: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d answers still owed",
                     $time, HANG_LIMIT, tracker.owed_answers.size());
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_MAP;
        idle_on  = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reads of an empty palette, extreme colors, hits at both
        // ends, reads inside and past the fill, ignored fields set high.
        send_item(ACT_READ, 24'hFFFFFF, 8'd0);
        send_item(ACT_READ, 24'h000000, 8'd255);
        send_item(ACT_MAP,  24'h000000, 8'd255);
        send_item(ACT_MAP,  24'hFFFFFF, 8'd0);
        send_item(ACT_MAP,  24'h000000, 8'd0);
        send_item(ACT_MAP,  24'hFFFFFF, 8'd255);
        send_item(ACT_READ, 24'hFFFFFF, 8'd0);
        send_item(ACT_READ, 24'h000000, 8'd1);
        send_item(ACT_READ, 24'h123456, 8'd2);
        send_item(ACT_READ, 24'h000000, 8'd255);
        send_item(ACT_MAP,  24'hA5A5A5, 8'hA5);
        send_item(ACT_MAP,  24'h5A5A5A, 8'h5A);
        send_item(ACT_MAP,  24'hA5A5A5, 8'd0);
        send_item(ACT_MAP,  24'h800001, 8'h80);
        send_item(ACT_MAP,  24'h5A5A5A, 8'hFF);
        send_item(ACT_READ, 24'h000000, 8'd3);
        send_item(ACT_READ, 24'h000000, 8'd5);
        send_item(ACT_READ, 24'hFFFFFF, 8'd128);
        drain_answers();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (i > 0 && i % DRAIN_EVERY == 0)
                drain_answers();
            if (idle_on && $urandom_range(0, 3) == 0)
                hold_input($urandom_range(1, 5));
            send_random_item();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.owed_answers.size() != 0)
            @(posedge clk);
        // Let any stray late answer show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d answers: %0d inserts, %0d hits, %0d overflows, %0d reads.",
                 tracker.checked, tracker.inserts, tracker.hits, tracker.overflows,
                 tracker.reads);
        $display("Palette held %0d of %0d entries at the end.", tracker.filled, PAL_ENTRIES);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pci_pkg.sv
design/pci_ctrl.sv
design/pci_datapath.sv
design/palette_color_indexer.sv
verif/tb_palette_color_indexer.sv
